[hdl/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// Text console writer package
// Shared widths, codes and the control/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam int CMD_W     = 2;
  localparam int CODE_W    = 8;
  localparam int INDEX_W   = 11;
  localparam int COL_OUT_W = 7;
  localparam int ROW_OUT_W = 5;
  localparam int CELL_W    = 16;
  localparam int COLOR_W   = 8;
  localparam int PADDR_W   = 2;
  localparam int PDATA_W   = 32;

  localparam logic [COLOR_W-1:0] RESET_COLOR    = 8'h0F;
  localparam logic [CODE_W-1:0]  BLANK_CHAR     = 8'h20;
  localparam logic [CODE_W-1:0]  NEWLINE_CODE   = 8'h0A;
  localparam logic [CODE_W-1:0]  BACKSPACE_CODE = 8'h08;

  localparam logic [PADDR_W-1:0] ADDR_TEXT_COLOR = 2'd0;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } tcw_op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_CLEAR,
    ST_DONE
  } tcw_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // latch the incoming request
    logic exec;        // execute the latched request
    logic sweep_step;  // advance the memory sweep by one cell
    logic sweep_copy;  // sweep copies rows up (scroll) instead of blanking
    logic sweep_init;  // sweep blanks with the reset attribute
    logic load_rsp;    // load the result register
  } tcw_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_clear;
    logic need_scroll;
    logic sweep_last;
  } tcw_sts_t;

endpackage

[hdl/text_console_writer.sv]
// ----------------------------------------------------------------------------
// Text console writer
// Character-cell text console with cursor, scrolling, clear and cell read.
// ----------------------------------------------------------------------------
// The console keeps a ROWS x COLUMNS screen of 16-bit cells (attribute in the
// high byte, character in the low byte) in a single-port-write, one-read-port
// memory, and takes one request at a time. A put of an ordinary character,
// a backspace, a newline without scroll, and a read each go through accept,
// execute and load result, in that order. A request that scrolls adds a
// sweep over every cell, and a clear adds the same: both walk the screen
// memory one cell per cycle, the scroll copying each cell above the last
// row from the row below, read in the cycle before its write, and blanking
// the last row. After reset the block runs a clearing pass over every cell
// before it accepts its first request; register writes on the APB port are
// taken at any time. The text_color register sits at byte address 0 and
// resets to 0x0F. A finished result waits in its output register, and the
// next request may be accepted while that result is still held; its own
// result then waits until the first is taken.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic                           clk,
  input  logic                           rst,
  // Request channel.
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic [tcw_pkg::CMD_W-1:0]      cmd,
  input  logic [tcw_pkg::CODE_W-1:0]     char_code,
  input  logic [tcw_pkg::INDEX_W-1:0]    cell_index,
  // Result channel.
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic [tcw_pkg::COL_OUT_W-1:0]  cursor_col,
  output logic [tcw_pkg::ROW_OUT_W-1:0]  cursor_row,
  output logic [tcw_pkg::CELL_W-1:0]     cell_value,
  // Register port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tcw_pkg::PADDR_W-1:0]    paddr,
  input  logic [tcw_pkg::PDATA_W-1:0]    pwdata,
  output logic [tcw_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);
  import tcw_pkg::*;

  logic [COLOR_W-1:0] text_color;
  tcw_ctl_t           ctl;
  tcw_sts_t           sts;
  logic               reg_hit;

  // Only the aligned address of the single register decodes; other
  // addresses read as zero and ignore writes.
  assign reg_hit = (paddr == ADDR_TEXT_COLOR);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? PDATA_W'(text_color) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= RESET_COLOR;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      text_color <= pwdata[COLOR_W-1:0];
    end
  end

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .cmd        (cmd),
    .char_code  (char_code),
    .cell_index (cell_index),
    .text_color (text_color),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .cell_value (cell_value)
  );

endmodule

[hdl/tcw_ctrl.sv]
// ----------------------------------------------------------------------------
// Text console controller
// Sequences request intake, execution, memory sweeps and the result handoff.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  input  tcw_pkg::tcw_sts_t sts,
  output tcw_pkg::tcw_ctl_t ctl
);
  import tcw_pkg::*;

  tcw_state_t state;
  tcw_state_t state_next;
  logic       rsp_free;

  assign rsp_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (sts.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.op_clear) begin
          state_next = ST_CLEAR;
        end else if (sts.need_scroll) begin
          state_next = ST_SCROLL;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_SCROLL, ST_CLEAR: begin
        if (sts.sweep_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (rsp_free) state_next = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

  always_comb begin
    ctl       = '0;
    req_stall = 1'b1;
    case (state)
      ST_INIT: begin
        ctl.sweep_step = 1'b1;
        ctl.sweep_init = 1'b1;
      end
      ST_IDLE: begin
        req_stall  = 1'b0;
        ctl.accept = req_valid;
      end
      ST_EXEC: begin
        ctl.exec = 1'b1;
      end
      ST_SCROLL: begin
        ctl.sweep_step = 1'b1;
        ctl.sweep_copy = 1'b1;
      end
      ST_CLEAR: begin
        ctl.sweep_step = 1'b1;
      end
      ST_DONE: begin
        ctl.load_rsp = rsp_free;
      end
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  a_load_into_free: assert property (@(posedge clk) disable iff (rst)
    ctl.load_rsp |-> !(rsp_valid && rsp_stall))
    else $error("result register loaded while a result is held");

  a_sweep_ends: assert property (@(posedge clk) disable iff (rst)
    (ctl.sweep_step && sts.sweep_last) |=> !ctl.sweep_step)
    else $error("sweep continued past the last cell");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == ST_EXEC))
    else $error("accepted request not executed");

endmodule

[hdl/tcw_datapath.sv]
// ----------------------------------------------------------------------------
// Text console datapath
// Screen memory, cursor, request latch, sweep pipeline and result register.
// ----------------------------------------------------------------------------
module tcw_datapath #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  tcw_pkg::tcw_ctl_t              ctl,
  output tcw_pkg::tcw_sts_t              sts,
  input  logic [tcw_pkg::CMD_W-1:0]      cmd,
  input  logic [tcw_pkg::CODE_W-1:0]     char_code,
  input  logic [tcw_pkg::INDEX_W-1:0]    cell_index,
  input  logic [tcw_pkg::COLOR_W-1:0]    text_color,
  output logic [tcw_pkg::COL_OUT_W-1:0]  cursor_col,
  output logic [tcw_pkg::ROW_OUT_W-1:0]  cursor_row,
  output logic [tcw_pkg::CELL_W-1:0]     cell_value
);
  import tcw_pkg::*;

  localparam int NCELLS = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(NCELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(NCELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(NCELLS - 1);
  localparam logic [ADDR_W-1:0] ROW_SPAN  = ADDR_W'(COLUMNS);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);

  logic [CELL_W-1:0] mem [NCELLS];

  // Latched request.
  logic [CMD_W-1:0]   item_op;
  logic [CODE_W-1:0]  item_code;
  logic [INDEX_W-1:0] item_idx;

  logic [COL_W-1:0] col;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] row_next;

  logic [ADDR_W-1:0] sweep_addr;
  logic              pipe_valid;
  logic              pipe_copy;
  logic [ADDR_W-1:0] pipe_addr;
  logic [CELL_W-1:0] pipe_blank;

  logic [CELL_W-1:0] rdata;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CELL_W-1:0] wdata;

  logic              is_put;
  logic              is_read;
  logic              is_newline;
  logic              is_backspace;
  logic              read_hit;
  logic              copy_phase;
  logic [ADDR_W-1:0] cur_addr;
  logic              exec_we;
  logic [ADDR_W-1:0] exec_addr;
  logic [CELL_W-1:0] exec_data;

  assign is_put       = (item_op == CMD_PUT);
  assign is_read      = (item_op == CMD_READ);
  assign is_newline   = (item_code == NEWLINE_CODE);
  assign is_backspace = (item_code == BACKSPACE_CODE);
  assign read_hit     = is_read && (int'(item_idx) < NCELLS);
  assign copy_phase   = ctl.sweep_copy && (sweep_addr < COPY_END);

  assign cur_addr  = ADDR_W'(row) * ROW_SPAN + ADDR_W'(col);
  assign exec_we   = ctl.exec && is_put && !is_newline && (!is_backspace || (col != '0));
  assign exec_addr = is_backspace ? (cur_addr - ADDR_W'(1)) : cur_addr;
  assign exec_data = is_backspace ? {text_color, BLANK_CHAR} : {text_color, item_code};

  assign sts.op_clear    = (item_op == CMD_CLEAR);
  assign sts.need_scroll = is_put && (row == LAST_ROW) &&
                           (is_newline || (!is_backspace && (col == LAST_COL)));
  assign sts.sweep_last  = (sweep_addr == LAST_CELL);

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      item_op   <= cmd;
      item_code <= char_code;
      item_idx  <= cell_index;
    end
  end

  // Cursor update for the executed request.
  always_comb begin
    col_next = col;
    row_next = row;
    if (ctl.exec) begin
      case (item_op)
        CMD_PUT: begin
          if (is_newline) begin
            col_next = '0;
            if (row != LAST_ROW) row_next = row + ROW_W'(1);
          end else if (is_backspace) begin
            if (col != '0) col_next = col - COL_W'(1);
          end else if (col == LAST_COL) begin
            col_next = '0;
            if (row != LAST_ROW) row_next = row + ROW_W'(1);
          end else begin
            col_next = col + COL_W'(1);
          end
        end
        CMD_CLEAR: begin
          col_next = '0;
          row_next = '0;
        end
        default: begin
          col_next = col;
          row_next = row;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
    end
  end

  // Sweep counter and one-stage write pipeline. The read for a copied cell
  // is issued in the cycle before its write, so blanks go through the same
  // stage to keep the write order.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
      pipe_valid <= 1'b0;
    end else begin
      pipe_valid <= ctl.sweep_step;
      if (ctl.sweep_step) begin
        sweep_addr <= sts.sweep_last ? '0 : sweep_addr + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sweep_step) begin
      pipe_addr  <= sweep_addr;
      pipe_copy  <= copy_phase;
      pipe_blank <= {(ctl.sweep_init ? RESET_COLOR : text_color), BLANK_CHAR};
    end
  end

  assign rd_en   = (ctl.sweep_step && copy_phase) || (ctl.exec && read_hit);
  assign rd_addr = ctl.sweep_step ? (sweep_addr + ROW_SPAN) : ADDR_W'(item_idx);
  assign we      = pipe_valid || exec_we;
  assign waddr   = pipe_valid ? pipe_addr : exec_addr;
  assign wdata   = pipe_valid ? (pipe_copy ? rdata : pipe_blank) : exec_data;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.load_rsp) begin
      cursor_col <= COL_OUT_W'(col);
      cursor_row <= ROW_OUT_W'(row);
      cell_value <= read_hit ? rdata : '0;
    end
  end

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (int'(col) < COLUMNS) && (int'(row) < ROWS))
    else $error("cursor outside the screen");

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(pipe_valid && exec_we))
    else $error("sweep write collides with a character write");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    (ctl.load_rsp && !is_read) |=> (cell_value == '0))
    else $error("cell value not zero for a non-read request");

endmodule
